FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

FILE: hw/rtl/rrts_pkg.sv
// Package with the types, codes and constants of the round-robin task scheduler.
`default_nettype none

package rrts_pkg;

  // Task table and ready queue geometry.
  localparam int NUM_TASKS = 16;
  localparam int TID_W     = $clog2(NUM_TASKS);
  localparam int CNT_W     = TID_W + 1;
  localparam int PRIO_W    = 8;
  localparam int PID_W     = 16;
  localparam int STAT_W    = 3;
  localparam int OP_W      = 3;
  localparam int KIND_W    = 2;
  localparam int ERR_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 8;

  // Task status codes.
  localparam logic [STAT_W-1:0] TS_UNUSED  = 3'd0;
  localparam logic [STAT_W-1:0] TS_RUNNING = 3'd1;
  localparam logic [STAT_W-1:0] TS_READY   = 3'd2;
  localparam logic [STAT_W-1:0] TS_BLOCKED = 3'd3;
  localparam logic [STAT_W-1:0] TS_WAITING = 3'd4;
  localparam logic [STAT_W-1:0] TS_HANGING = 3'd5;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
  localparam logic [OP_W-1:0] OP_PREEMPT = 3'd1;
  localparam logic [OP_W-1:0] OP_YIELD   = 3'd2;
  localparam logic [OP_W-1:0] OP_BLOCK   = 3'd3;
  localparam logic [OP_W-1:0] OP_UNBLOCK = 3'd4;

  // Block kind that has no meaning.
  localparam logic [KIND_W-1:0] KIND_BAD = 2'd3;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_OK      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_STATE   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_QUEUED  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_NO_TASK = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEF_PRIO  = 1'd1;

  // Reset values.
  localparam logic [PRIO_W-1:0] MAIN_PRIORITY   = 8'd31;
  localparam logic [TID_W-1:0]  RESET_IDLE_TASK = 4'd15;
  localparam logic [PRIO_W-1:0] RESET_DEF_PRIO  = 8'd31;
  localparam logic [PID_W-1:0]  RESET_PID       = 16'd1;

  // Ready queue cell modes.
  localparam logic [1:0] Q_HOLD   = 2'd0;
  localparam logic [1:0] Q_APPEND = 2'd1;
  localparam logic [1:0] Q_POP    = 2'd2;
  localparam logic [1:0] Q_PUSH   = 2'd3;

  // Command broadcast to every ready queue cell.
  typedef struct packed {
    logic [1:0]       mode;
    logic             ins;    // pop also appends data at the tail
    logic [CNT_W-1:0] count;  // queue fill before the transaction
    logic [TID_W-1:0] data;
  } qcmd_t;

  // Command broadcast to every task cell; the b write wins on status.
  typedef struct packed {
    logic              a_en;
    logic [TID_W-1:0]  a_id;
    logic [STAT_W-1:0] a_status;
    logic              a_load;    // load priority and ticks from a_prio
    logic              a_reload;  // reload ticks from the stored priority
    logic [PRIO_W-1:0] a_prio;
    logic              b_en;
    logic [TID_W-1:0]  b_id;      // task that becomes the running one
  } tcmd_t;

  // What a task cell shows to the control logic.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PRIO_W-1:0] ticks;
  } tview_t;

  // True for blocked, waiting and hanging tasks.
  function automatic logic is_sleeping(input logic [STAT_W-1:0] st);
    return (st == TS_BLOCKED) || (st == TS_WAITING) || (st == TS_HANGING);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/round_robin_task_scheduler_top.sv
// Top level of the round-robin task scheduler: control, task cells and queue chain.
//
// Channel   Direction  Handshake              Payload
// input     in         start high, busy low   in_operation, in_task_id, in_priority_req,
//                                             in_block_kind
// result    out        out_valid, one cycle   out_running_task, out_switched,
//                                             out_assigned_pid, out_running_ticks,
//                                             out_error_code
// config    in         cfg_we                 cfg_index, cfg_wdata
//
// In every transaction the accept edge registers the command, and
// the next edge updates the task cells and the queue chain in one step.
// The result is shown in the cycle after that, while busy is already low again,
// so a new transaction can be accepted at the edge that ends the result cycle.
// Reset is synchronous and active low; no clearing pass is needed.
// The receiver cannot stall the block, so results are never held.
`default_nettype none

module round_robin_task_scheduler_top
  import rrts_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  wire  [OP_W-1:0]      in_operation,
  input  wire  [TID_W-1:0]     in_task_id,
  input  wire  [PRIO_W-1:0]    in_priority_req,
  input  wire  [KIND_W-1:0]    in_block_kind,
  output logic                 out_valid,
  output logic [TID_W-1:0]     out_running_task,
  output logic                 out_switched,
  output logic [PID_W-1:0]     out_assigned_pid,
  output logic [PRIO_W-1:0]    out_running_ticks,
  output logic [ERR_W-1:0]     out_error_code,
  input  wire                  cfg_we,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [CFG_DAT_W-1:0] cfg_wdata
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic              state_r;
  logic [OP_W-1:0]   op_r;
  logic [TID_W-1:0]  tid_r;
  logic [PRIO_W-1:0] preq_r;
  logic [KIND_W-1:0] kind_r;
  logic [TID_W-1:0]  idle_r;
  logic [PRIO_W-1:0] defp_r;
  logic [TID_W-1:0]  cur_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PID_W-1:0]  pid_r;
  logic              out_valid_r;
  logic              out_sw_r;
  logic [PID_W-1:0]  out_pid_r;
  logic [ERR_W-1:0]  out_err_r;

  logic [TID_W-1:0]  cur_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic [PID_W-1:0]  pid_nxt;
  logic [ERR_W-1:0]  err_nxt;
  logic [PID_W-1:0]  pid_res_nxt;

  logic              accept;
  logic              exec;
  qcmd_t             qcmd;
  tcmd_t             tcmd;
  tview_t            view_w [NUM_TASKS];
  logic [TID_W-1:0]  slot_w [NUM_TASKS];
  logic [STAT_W-1:0] st_tid;
  logic [STAT_W-1:0] st_idle;
  logic [TID_W-1:0]  head_id;
  logic [PRIO_W-1:0] new_prio;

  assign accept = start && (state_r == S_IDLE);
  assign exec   = (state_r == S_EXEC);
  assign busy   = exec;

  // Sequencer: idle until a command arrives, then the execute state, then back to idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE:  state_r <= accept ? S_EXEC : S_IDLE;
        S_EXEC:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Command capture.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_operation;
      tid_r  <= in_task_id;
      preq_r <= in_priority_req;
      kind_r <= in_block_kind;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r <= RESET_IDLE_TASK;
      defp_r <= RESET_DEF_PRIO;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IDLE_TASK: idle_r <= cfg_wdata[TID_W-1:0];
        REG_DEF_PRIO:  defp_r <= cfg_wdata[PRIO_W-1:0];
        default:       idle_r <= idle_r;
      endcase
    end
  end

  // Table lookups for the task named by the command and the idle task.
  assign st_tid   = view_w[tid_r].status;
  assign st_idle  = view_w[idle_r].status;
  assign head_id  = slot_w[0];
  assign new_prio = (preq_r == '0) ? defp_r : preq_r;

  // Decode the command into broadcasts for the task cells and the queue chain.
  always_comb begin
    qcmd        = '0;
    qcmd.mode   = Q_HOLD;
    qcmd.count  = cnt_r;
    tcmd        = '0;
    cur_nxt     = cur_r;
    cnt_nxt     = cnt_r;
    pid_nxt     = pid_r;
    err_nxt     = ERR_OK;
    pid_res_nxt = '0;
    if (exec) begin
      unique case (op_r)
        OP_CREATE: begin
          if (tid_r == cur_r) begin
            err_nxt = ERR_STATE;
          end else if (st_tid == TS_READY) begin
            err_nxt = ERR_QUEUED;
          end else begin
            pid_nxt       = pid_r + PID_W'(1);
            pid_res_nxt   = pid_nxt;
            tcmd.a_en     = 1'b1;
            tcmd.a_id     = tid_r;
            tcmd.a_status = TS_READY;
            tcmd.a_load   = 1'b1;
            tcmd.a_prio   = new_prio;
            qcmd.mode     = Q_APPEND;
            qcmd.data     = tid_r;
            cnt_nxt       = cnt_r + CNT_W'(1);
          end
        end
        OP_PREEMPT, OP_YIELD: begin
          // Requeue the running task at the tail, then pop the head.
          tcmd.a_en     = 1'b1;
          tcmd.a_id     = cur_r;
          tcmd.a_status = TS_READY;
          tcmd.a_reload = (op_r == OP_PREEMPT);
          cur_nxt       = (cnt_r == '0) ? cur_r : head_id;
          tcmd.b_en     = 1'b1;
          tcmd.b_id     = cur_nxt;
          qcmd.mode     = Q_POP;
          qcmd.ins      = 1'b1;
          qcmd.data     = cur_r;
        end
        OP_BLOCK: begin
          if (kind_r == KIND_BAD) begin
            err_nxt = ERR_STATE;
          end else if ((cnt_r == '0) && !((idle_r == cur_r) || is_sleeping(st_idle))) begin
            err_nxt = ERR_NO_TASK;
          end else begin
            tcmd.a_en     = 1'b1;
            tcmd.a_id     = cur_r;
            tcmd.a_status = TS_BLOCKED + STAT_W'(kind_r);
            tcmd.b_en     = 1'b1;
            if (cnt_r == '0) begin
              // Empty queue: the idle task is woken and runs at once.
              cur_nxt = idle_r;
            end else begin
              cur_nxt   = head_id;
              qcmd.mode = Q_POP;
              cnt_nxt   = cnt_r - CNT_W'(1);
            end
            tcmd.b_id = cur_nxt;
          end
        end
        OP_UNBLOCK: begin
          if (st_tid == TS_READY) begin
            err_nxt = ERR_QUEUED;
          end else if (!is_sleeping(st_tid)) begin
            err_nxt = ERR_STATE;
          end else begin
            tcmd.a_en     = 1'b1;
            tcmd.a_id     = tid_r;
            tcmd.a_status = TS_READY;
            qcmd.mode     = Q_PUSH;
            qcmd.data     = tid_r;
            cnt_nxt       = cnt_r + CNT_W'(1);
          end
        end
        default: begin
          err_nxt = ERR_OK;
        end
      endcase
    end
  end

  // Scheduler state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '0;
      cnt_r <= '0;
      pid_r <= RESET_PID;
    end else begin
      cur_r <= cur_nxt;
      cnt_r <= cnt_nxt;
      pid_r <= pid_nxt;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_sw_r  <= (cur_nxt != cur_r);
      out_pid_r <= pid_res_nxt;
      out_err_r <= err_nxt;
    end
  end

  // Task cells, one per task.
  for (genvar k = 0; k < NUM_TASKS; k++) begin : g_task
    rrts_tcell u_tcell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (TID_W'(k)),
      .cmd      (tcmd),
      .view     (view_w[k])
    );
  end

  // Ready queue chain; slot 0 is the head and takes pushed tasks.
  for (genvar k = 0; k < NUM_TASKS; k++) begin : g_queue
    logic [TID_W-1:0] left_id;
    logic [TID_W-1:0] right_id;
    if (k == 0) begin : g_first
      assign left_id = qcmd.data;
    end else begin : g_mid
      assign left_id = slot_w[k-1];
    end
    if (k == NUM_TASKS - 1) begin : g_last
      assign right_id = '0;
    end else begin : g_inner
      assign right_id = slot_w[k+1];
    end
    rrts_qcell u_qcell (
      .clk      (clk),
      .cell_idx (TID_W'(k)),
      .cmd      (qcmd),
      .left_id  (left_id),
      .right_id (right_id),
      .slot_id  (slot_w[k])
    );
  end

  assign out_valid         = out_valid_r;
  assign out_running_task  = cur_r;
  assign out_switched      = out_sw_r;
  assign out_assigned_pid  = out_pid_r;
  assign out_running_ticks = view_w[cur_r].ticks;
  assign out_error_code    = out_err_r;

endmodule

`default_nettype wire

FILE: hw/rtl/rrts_qcell.sv
// One slot of the ready queue chain; slot 0 is the queue head.
`default_nettype none

module rrts_qcell
  import rrts_pkg::*;
(
  input  wire              clk,
  input  wire  [TID_W-1:0] cell_idx,
  input  qcmd_t            cmd,
  input  wire  [TID_W-1:0] left_id,
  input  wire  [TID_W-1:0] right_id,
  output logic [TID_W-1:0] slot_id
);

  logic [TID_W-1:0] slot_r;
  logic             at_tail;
  logic             before_tail;

  // Position of this slot relative to the current tail.
  assign at_tail     = (CNT_W'(cell_idx) == cmd.count);
  assign before_tail = ((CNT_W'(cell_idx) + CNT_W'(1)) == cmd.count);

  // Append writes the tail slot, pop shifts toward the head and, with ins, refills the tail; push shifts away.
  always_ff @(posedge clk) begin
    case (cmd.mode)
      Q_APPEND: begin
        if (at_tail) begin
          slot_r <= cmd.data;
        end
      end
      Q_POP: begin
        if (cmd.ins && before_tail) begin
          slot_r <= cmd.data;
        end else begin
          slot_r <= right_id;
        end
      end
      Q_PUSH: begin
        slot_r <= left_id;
      end
      default: begin
        slot_r <= slot_r;
      end
    endcase
  end

  assign slot_id = slot_r;

endmodule

`default_nettype wire

FILE: hw/rtl/rrts_tcell.sv
// One entry of the task table: status, priority and tick budget of one task.
`default_nettype none

module rrts_tcell
  import rrts_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire  [TID_W-1:0] cell_idx,
  input  tcmd_t            cmd,
  output tview_t           view
);

  logic [STAT_W-1:0] status_r;
  logic [PRIO_W-1:0] prio_r;
  logic [PRIO_W-1:0] ticks_r;
  logic              hit_a;
  logic              hit_b;
  logic              is_main;

  assign hit_a   = cmd.a_en && (cmd.a_id == cell_idx);
  assign hit_b   = cmd.b_en && (cmd.b_id == cell_idx);
  assign is_main = (cell_idx == '0);

  // The main task runs out of reset; all other tasks are unused.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= is_main ? TS_RUNNING : TS_UNUSED;
      prio_r   <= is_main ? MAIN_PRIORITY : '0;
      ticks_r  <= is_main ? MAIN_PRIORITY : '0;
    end else begin
      if (hit_b) begin
        status_r <= TS_RUNNING;
      end else if (hit_a) begin
        status_r <= cmd.a_status;
      end
      if (hit_a && cmd.a_load) begin
        prio_r  <= cmd.a_prio;
        ticks_r <= cmd.a_prio;
      end else if (hit_a && cmd.a_reload) begin
        ticks_r <= prio_r;
      end
    end
  end

  assign view.status = status_r;
  assign view.ticks  = ticks_r;

endmodule

`default_nettype wire

FILE: hw/rtl/rrts_checker.sv
// Port-level checker for the round-robin task scheduler and its bind statement.
`default_nettype none

`include "assert_macros.svh"

module rrts_checker
  import rrts_pkg::*;
(
  input wire              clk,
  input wire              rst_n,
  input wire              start,
  input wire              busy,
  input wire              out_valid,
  input wire [TID_W-1:0]  out_running_task,
  input wire              out_switched,
  input wire [PID_W-1:0]  out_assigned_pid,
  input wire [ERR_W-1:0]  out_error_code
);

  // An accepted transaction makes the block busy in the next cycle.
  `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

  // A busy cycle is always followed by a result strobe and a free block.
  `ASSERT_NEXT(a_busy_result, clk, rst_n, busy, out_valid && !busy)

  // A failed transaction neither switches nor hands out a pid.
  `ASSERT_IMPLY(a_err_quiet, clk, rst_n, out_valid && (out_error_code != ERR_OK),
                !out_switched && (out_assigned_pid == '0))

  // The switched flag agrees with a change of the running task.
  `ASSERT_IMPLY(a_switch_flag, clk, rst_n, out_valid,
                out_switched == (out_running_task != $past(out_running_task)))

endmodule

bind round_robin_task_scheduler_top rrts_checker u_rrts_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_running_task (out_running_task),
  .out_switched     (out_switched),
  .out_assigned_pid (out_assigned_pid),
  .out_error_code   (out_error_code)
);

`default_nettype wire

FILE: sim/round_robin_task_scheduler_top_tb.sv
// Self-checking testbench for the round-robin task scheduler top level.
module round_robin_task_scheduler_top_tb;
  import rrts_pkg::*;

  // Operation codes that the scheduler ignores.
  localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

  localparam int NUM_DIRECTED = 23;
  localparam int RANDOM_PER_PHASE = 400;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 4;

  // One scheduler command and the result it produces.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TID_W-1:0]  tid;
    logic [PRIO_W-1:0] prio;
    logic [KIND_W-1:0] kind;
  } sched_op_t;

  typedef struct packed {
    logic [TID_W-1:0]  running;
    logic              switched;
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] ticks;
    logic [ERR_W-1:0]  err;
  } sched_result_t;

  typedef struct packed {
    sched_op_t     cmd;
    logic          typed;
    sched_result_t want;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      in_operation = '0;
  logic [TID_W-1:0]     in_task_id = '0;
  logic [PRIO_W-1:0]    in_priority_req = '0;
  logic [KIND_W-1:0]    in_block_kind = '0;
  logic                 out_valid;
  logic [TID_W-1:0]     out_running_task;
  logic                 out_switched;
  logic [PID_W-1:0]     out_assigned_pid;
  logic [PRIO_W-1:0]    out_running_ticks;
  logic [ERR_W-1:0]     out_error_code;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  round_robin_task_scheduler_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_task_id        (in_task_id),
    .in_priority_req   (in_priority_req),
    .in_block_kind     (in_block_kind),
    .out_valid         (out_valid),
    .out_running_task  (out_running_task),
    .out_switched      (out_switched),
    .out_assigned_pid  (out_assigned_pid),
    .out_running_ticks (out_running_ticks),
    .out_error_code    (out_error_code),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Scheduler state as the testbench tracks it.
  logic [STAT_W-1:0] task_state  [NUM_TASKS];
  logic [PRIO_W-1:0] task_prio   [NUM_TASKS];
  logic [PRIO_W-1:0] task_budget [NUM_TASKS];
  logic [TID_W-1:0]  ready_ring  [NUM_TASKS];
  logic [TID_W-1:0]  ring_head;
  logic [CNT_W-1:0]  ring_fill;
  logic [TID_W-1:0]  cur_task;
  logic [PID_W-1:0]  pid_ctr;
  logic [TID_W-1:0]  idle_cfg;
  logic [PRIO_W-1:0] def_prio_cfg;

  sched_result_t expected_q [$];
  int fail_count = 0;
  int stall_cycles = 0;
  int n_cmds = 0;
  int n_ignored = 0;
  int n_switches = 0;
  int n_created = 0;
  int err_hist [4] = '{0, 0, 0, 0};

  function automatic logic asleep(input logic [STAT_W-1:0] st);
    return st == TS_BLOCKED || st == TS_WAITING || st == TS_HANGING;
  endfunction

  function automatic void ring_append(input logic [TID_W-1:0] t);
    if (ring_fill < NUM_TASKS) begin
      ready_ring[TID_W'(ring_head + ring_fill)] = t;
      ring_fill = ring_fill + 1'b1;
    end
  endfunction

  function automatic void ring_push(input logic [TID_W-1:0] t);
    if (ring_fill < NUM_TASKS) begin
      ring_head = ring_head - 1'b1;
      ready_ring[ring_head] = t;
      ring_fill = ring_fill + 1'b1;
    end
  endfunction

  // Pops the head of the ready queue, waking the idle task if the queue is empty.
  function automatic void hand_over();
    logic [TID_W-1:0] nxt;
    if (ring_fill == 0) begin
      task_state[idle_cfg] = TS_READY;
      ring_push(idle_cfg);
    end
    nxt = ready_ring[ring_head];
    ring_head = ring_head + 1'b1;
    ring_fill = ring_fill - 1'b1;
    task_state[nxt] = TS_RUNNING;
    cur_task = nxt;
  endfunction

  // Applies one command to the tracked state and returns the result it should give.
  function automatic sched_result_t predict_schedule(input sched_op_t c);
    sched_result_t r;
    logic [TID_W-1:0] prev;
    logic [PRIO_W-1:0] p;
    r = '0;
    prev = cur_task;
    case (c.op)
      OP_CREATE: begin
        if (c.tid == cur_task) begin
          r.err = ERR_STATE;
        end else if (task_state[c.tid] == TS_READY) begin
          r.err = ERR_QUEUED;
        end else begin
          p = (c.prio == 0) ? def_prio_cfg : c.prio;
          pid_ctr = pid_ctr + 1'b1;
          r.pid = pid_ctr;
          task_prio[c.tid] = p;
          task_budget[c.tid] = p;
          task_state[c.tid] = TS_READY;
          ring_append(c.tid);
        end
      end
      OP_PREEMPT, OP_YIELD: begin
        if (c.op == OP_PREEMPT) task_budget[cur_task] = task_prio[cur_task];
        task_state[cur_task] = TS_READY;
        ring_append(cur_task);
        hand_over();
      end
      OP_BLOCK: begin
        if (c.kind == KIND_BAD) begin
          r.err = ERR_STATE;
        end else if (ring_fill == 0 && !(idle_cfg == cur_task ||
                                         asleep(task_state[idle_cfg]))) begin
          r.err = ERR_NO_TASK;
        end else begin
          task_state[cur_task] = STAT_W'(TS_BLOCKED + c.kind);
          hand_over();
        end
      end
      OP_UNBLOCK: begin
        if (task_state[c.tid] == TS_READY) begin
          r.err = ERR_QUEUED;
        end else if (!asleep(task_state[c.tid])) begin
          r.err = ERR_STATE;
        end else begin
          task_state[c.tid] = TS_READY;
          ring_push(c.tid);
        end
      end
      default: ;
    endcase
    r.running = cur_task;
    r.switched = (cur_task != prev);
    r.ticks = task_budget[cur_task];
    return r;
  endfunction

  // Random command, mostly well-formed: creates of free tasks, unblocks of sleeping ones.
  function automatic sched_op_t random_command();
    sched_op_t c;
    int pick;
    int cands [$];
    c.tid = TID_W'($urandom_range(NUM_TASKS - 1, 0));
    c.kind = KIND_W'($urandom_range(3, 0));
    pick = $urandom_range(9, 0);
    if (pick < 2) c.prio = '0;
    else if (pick == 2) c.prio = '1;
    else if (pick == 3) c.prio = 8'd1;
    else c.prio = PRIO_W'($urandom_range(255, 0));
    pick = $urandom_range(99, 0);
    if (pick < 4) begin
      c.op = OP_W'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO));
    end else if (pick < 34) begin
      c.op = OP_CREATE;
      for (int t = 0; t < NUM_TASKS; t++)
        if (task_state[t] != TS_READY && t != cur_task) cands.push_back(t);
      if (cands.size() != 0 && $urandom_range(9, 0) < 8)
        c.tid = TID_W'(cands[$urandom_range(cands.size() - 1, 0)]);
    end else if (pick < 46) begin
      c.op = OP_PREEMPT;
    end else if (pick < 58) begin
      c.op = OP_YIELD;
    end else if (pick < 78) begin
      c.op = OP_BLOCK;
      c.kind = ($urandom_range(19, 0) == 0) ? KIND_BAD : KIND_W'($urandom_range(2, 0));
    end else begin
      c.op = OP_UNBLOCK;
      for (int t = 0; t < NUM_TASKS; t++)
        if (asleep(task_state[t])) cands.push_back(t);
      if (cands.size() != 0 && $urandom_range(9, 0) < 8)
        c.tid = TID_W'(cands[$urandom_range(cands.size() - 1, 0)]);
    end
    return c;
  endfunction

  task automatic reset_model();
    for (int t = 0; t < NUM_TASKS; t++) begin
      task_state[t] = TS_UNUSED;
      task_prio[t] = '0;
      task_budget[t] = '0;
      ready_ring[t] = '0;
    end
    task_state[0] = TS_RUNNING;
    task_prio[0] = MAIN_PRIORITY;
    task_budget[0] = MAIN_PRIORITY;
    ring_head = '0;
    ring_fill = '0;
    cur_task = '0;
    pid_ctr = RESET_PID;
    idle_cfg = RESET_IDLE_TASK;
    def_prio_cfg = RESET_DEF_PRIO;
  endtask

  // Drives one command, waits for the block to take it and records what it should return.
  task automatic send_item(input sched_op_t c, input int idle_pct, input logic typed,
                           input sched_result_t want);
    int gap;
    sched_result_t r;
    gap = ($urandom_range(99, 0) < idle_pct) ? $urandom_range(3, 1) : 0;
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_operation <= c.op;
    in_task_id <= c.tid;
    in_priority_req <= c.prio;
    in_block_kind <= c.kind;
    do @(posedge clk); while (busy);
    r = predict_schedule(c);
    expected_q.push_back(typed ? want : r);
    n_cmds++;
    if (c.op > OP_UNBLOCK) n_ignored++;
    if (r.switched) n_switches++;
    if (c.op == OP_CREATE && r.err == ERR_OK) n_created++;
    err_hist[r.err]++;
  endtask

  // Lets every outstanding transaction finish so the block is idle.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_IDLE_TASK) idle_cfg = TID_W'(val);
    else def_prio_cfg = PRIO_W'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random commands until the given number of meaningful ones has been taken.
  task automatic run_random(input int n_items, input int idle_pct);
    sched_op_t c;
    int counted;
    counted = 0;
    while (counted < n_items) begin
      c = random_command();
      send_item(c, idle_pct, 1'b0, '0);
      if (c.op <= OP_UNBLOCK) counted++;
    end
  endtask

  // Result checker: every result must match the oldest outstanding expectation.
  always @(posedge clk) begin
    sched_result_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, running_task %0d error_code %0d",
                 $time, out_running_task, out_error_code);
        fail_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_running_task !== exp_r.running) begin
          $display("%0t: running_task expected %0d, got %0d",
                   $time, exp_r.running, out_running_task);
          fail_count++;
        end
        if (out_switched !== exp_r.switched) begin
          $display("%0t: switched expected %0d, got %0d", $time, exp_r.switched, out_switched);
          fail_count++;
        end
        if (out_assigned_pid !== exp_r.pid) begin
          $display("%0t: assigned_pid expected %0d, got %0d",
                   $time, exp_r.pid, out_assigned_pid);
          fail_count++;
        end
        if (out_running_ticks !== exp_r.ticks) begin
          $display("%0t: running_ticks expected %0d, got %0d",
                   $time, exp_r.ticks, out_running_ticks);
          fail_count++;
        end
        if (out_error_code !== exp_r.err) begin
          $display("%0t: error_code expected %0d, got %0d", $time, exp_r.err, out_error_code);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: ends the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || cfg_we) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("round_robin_task_scheduler_top test failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  dir_row_t directed_rows [NUM_DIRECTED];

  initial begin
    // Error cases first, then ignored opcodes and a walk through create, preempt, yield, block and unblock.
    directed_rows = '{
      '{'{OP_UNBLOCK, 4'd0, 8'd0, 2'd0}, 1'b1, '{4'd0, 1'b0, 16'd0, 8'd31, ERR_STATE}},
      '{'{OP_CREATE, 4'd0, 8'd5, 2'd0}, 1'b1, '{4'd0, 1'b0, 16'd0, 8'd31, ERR_STATE}},
      '{'{OP_BLOCK, 4'd0, 8'd0, KIND_BAD}, 1'b1, '{4'd0, 1'b0, 16'd0, 8'd31, ERR_STATE}},
      '{'{OP_BLOCK, 4'd0, 8'd0, 2'd0}, 1'b1, '{4'd0, 1'b0, 16'd0, 8'd31, ERR_NO_TASK}},
      '{'{OP_YIELD, 4'd9, 8'd77, 2'd1}, 1'b1, '{4'd0, 1'b0, 16'd0, 8'd31, ERR_OK}},
      '{'{OP_UNDEF_LO, 4'd15, 8'd255, 2'd3}, 1'b1, '{4'd0, 1'b0, 16'd0, 8'd31, ERR_OK}},
      '{'{OP_UNDEF_HI, 4'd0, 8'd0, 2'd0}, 1'b1, '{4'd0, 1'b0, 16'd0, 8'd31, ERR_OK}},
      '{'{OP_CREATE, 4'd15, 8'd0, 2'd0}, 1'b1, '{4'd0, 1'b0, 16'd2, 8'd31, ERR_OK}},
      '{'{OP_CREATE, 4'd15, 8'd200, 2'd0}, 1'b1, '{4'd0, 1'b0, 16'd0, 8'd31, ERR_QUEUED}},
      '{'{OP_UNBLOCK, 4'd15, 8'd0, 2'd0}, 1'b1, '{4'd0, 1'b0, 16'd0, 8'd31, ERR_QUEUED}},
      '{'{OP_UNBLOCK, 4'd3, 8'd0, 2'd0}, 1'b1, '{4'd0, 1'b0, 16'd0, 8'd31, ERR_STATE}},
      '{'{OP_CREATE, 4'd1, 8'd255, 2'd0}, 1'b1, '{4'd0, 1'b0, 16'd3, 8'd31, ERR_OK}},
      '{'{OP_PREEMPT, 4'd0, 8'd0, 2'd0}, 1'b0, '0},
      '{'{OP_BLOCK, 4'd0, 8'd0, 2'd1}, 1'b0, '0},
      '{'{OP_BLOCK, 4'd0, 8'd0, 2'd2}, 1'b0, '0},
      '{'{OP_BLOCK, 4'd0, 8'd0, 2'd0}, 1'b0, '0},
      '{'{OP_CREATE, 4'd0, 8'd0, 2'd0}, 1'b0, '0},
      '{'{OP_UNBLOCK, 4'd1, 8'd0, 2'd0}, 1'b0, '0},
      '{'{OP_UNBLOCK, 4'd1, 8'd0, 2'd0}, 1'b0, '0},
      '{'{OP_YIELD, 4'd0, 8'd0, 2'd0}, 1'b0, '0},
      '{'{OP_CREATE, 4'd2, 8'd1, 2'd0}, 1'b0, '0},
      '{'{OP_PREEMPT, 4'd0, 8'd0, 2'd0}, 1'b0, '0},
      '{'{OP_BLOCK, 4'd0, 8'd0, 2'd0}, 1'b0, '0}
    };
    reset_model();

    // Synchronous reset held low at the start, then released on a falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++)
      send_item(directed_rows[i].cmd, 29, directed_rows[i].typed, directed_rows[i].want);

    // Low extremes of both registers, sender idling often.
    drain();
    write_reg(REG_IDLE_TASK, 8'd0);
    write_reg(REG_DEF_PRIO, 8'd1);
    run_random(RANDOM_PER_PHASE, 29);

    // High extremes, sender idling more.
    drain();
    write_reg(REG_IDLE_TASK, 8'd15);
    write_reg(REG_DEF_PRIO, 8'd255);
    run_random(RANDOM_PER_PHASE, 52);

    // Mid-range settings, back-to-back transactions.
    drain();
    write_reg(REG_IDLE_TASK, CFG_DAT_W'($urandom_range(14, 1)));
    write_reg(REG_DEF_PRIO, CFG_DAT_W'($urandom_range(254, 2)));
    run_random(RANDOM_PER_PHASE, 0);

    // Idle task set to the running task, so it can wake itself after blocking.
    drain();
    write_reg(REG_IDLE_TASK, CFG_DAT_W'(cur_task));
    write_reg(REG_DEF_PRIO, CFG_DAT_W'(RESET_DEF_PRIO));
    run_random(RANDOM_PER_PHASE, 0);

    drain();
    $display("Ran %0d commands (%0d ignored) over 5 register settings: %0d switches, %0d creates.",
             n_cmds, n_ignored, n_switches, n_created);
    $display("Error codes seen: ok %0d, state %0d, queued %0d, nothing runnable %0d.",
             err_hist[0], err_hist[1], err_hist[2], err_hist[3]);
    if (fail_count == 0) begin
      $display("round_robin_task_scheduler_top test passed");
    end else begin
      $display("round_robin_task_scheduler_top test failed");
    end
    $finish;
  end

endmodule
